// File: rtl/aeskx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeskx_pkg: shared types and tables for the AES key expansion block
// Key size codes, queue item layout, back-end states, S-box and round
// constants.
// ----------------------------------------------------------------------------
package aeskx_pkg;

    // key size codes; the unused code runs as a 256-bit key
    localparam logic [1:0] KX_MODE_128 = 2'd0;
    localparam logic [1:0] KX_MODE_192 = 2'd1;
    localparam logic [1:0] KX_MODE_256 = 2'd2;

    localparam int KX_WORD_W  = 32;
    localparam int KX_IDX_W   = 6;
    localparam int KX_POS_W   = 3;
    localparam int KX_WIN_D   = 8;
    localparam int KX_RCON_W  = 4;

    // item queue between front and back
    localparam int KX_QDEPTH  = 2;
    localparam int KX_QPTR_W  = $clog2(KX_QDEPTH);
    localparam int KX_QCNT_W  = $clog2(KX_QDEPTH + 1);

    // classified key word handed from front to back
    typedef struct packed {
        logic [KX_WORD_W-1:0] word;
        logic [KX_POS_W-1:0]  pos;
        logic                 last_key;
        logic [1:0]           mode;
    } t_kx_item;

    typedef enum logic {
        BK_IDLE,
        BK_EXPAND
    } t_back_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [16] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,
        8'h80,8'h1b,8'h36,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    // key length minus one, in words
    function automatic logic [KX_POS_W-1:0] kx_nk_m1(input logic [1:0] mode);
        logic [KX_POS_W-1:0] v;
        unique case (mode)
            KX_MODE_128: v = 3'd3;
            KX_MODE_192: v = 3'd5;
            default:     v = 3'd7;
        endcase
        return v;
    endfunction

    // index of the final schedule word: 4*(Nk+7)-1
    function automatic logic [KX_IDX_W-1:0] kx_last_idx(input logic [1:0] mode);
        logic [KX_IDX_W-1:0] v;
        unique case (mode)
            KX_MODE_128: v = 6'd43;
            KX_MODE_192: v = 6'd51;
            default:     v = 6'd59;
        endcase
        return v;
    endfunction

    function automatic logic [KX_WORD_W-1:0] kx_sub_word(input logic [KX_WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: rtl/aeskx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeskx_queue: short item queue between front and back
// Register-based FIFO of classified key words; lets the front keep taking
// key words while the back runs an expansion.
// ----------------------------------------------------------------------------
module aeskx_queue
    import aeskx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_kx_item i_item,
    output logic     o_full,
    output logic     o_valid,
    output t_kx_item o_item,
    input  logic     i_pop
);

    t_kx_item               r_mem [KX_QDEPTH];
    logic [KX_QPTR_W-1:0]   r_wr_ptr;
    logic [KX_QPTR_W-1:0]   r_rd_ptr;
    logic [KX_QCNT_W-1:0]   r_count;
    logic [KX_QPTR_W-1:0]   n_wr_ptr;
    logic [KX_QPTR_W-1:0]   n_rd_ptr;

    assign o_full  = (r_count == KX_QCNT_W'(KX_QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == KX_QPTR_W'(KX_QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == KX_QPTR_W'(KX_QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");

endmodule

// File: rtl/aeskx_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeskx_front: key word intake and classification
// Holds the key size register and the loaded-word count, tags each key
// word with its position and whether it completes the key.
// ----------------------------------------------------------------------------
module aeskx_front
    import aeskx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [KX_WORD_W-1:0] s_axis_tdata,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output t_kx_item             o_q_item
);

    logic [1:0]          r_mode;
    logic [KX_POS_W-1:0] r_loaded;
    logic                w_last_key;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !i_q_full;
    assign o_q_push      = s_axis_tvalid && !i_q_full;

    // classify the incoming word
    assign w_last_key = (r_loaded == kx_nk_m1(r_mode));

    always_comb begin
        o_q_item.word     = s_axis_tdata;
        o_q_item.pos      = r_loaded;
        o_q_item.last_key = w_last_key;
        o_q_item.mode     = r_mode;
    end

    // mode register and loaded-word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= KX_MODE_256;
            r_loaded <= '0;
        end else if (i_cfg_valid) begin
            r_mode   <= i_cfg_data;
            r_loaded <= '0;
        end else if (o_q_push) begin
            r_loaded <= w_last_key ? '0 : r_loaded + 1'b1;
        end
    end

endmodule

// File: rtl/aeskx_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeskx_back: key window and schedule generator
// Echoes each key word, then after the last key word produces the rest of
// the schedule one word per cycle, while m_axis_tready allows, into an output register.
// ----------------------------------------------------------------------------
module aeskx_back
    import aeskx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  t_kx_item             i_q_item,
    output logic                 o_q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [KX_WORD_W-1:0] o_word,
    output logic [KX_IDX_W-1:0]  o_idx,
    output logic                 o_last
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [KX_WORD_W-1:0] r_window [KX_WIN_D];
    logic [KX_WORD_W-1:0] r_prev;
    logic [KX_IDX_W-1:0]  r_idx;
    logic [KX_POS_W-1:0]  r_r;
    logic [KX_RCON_W-1:0] r_rc;
    logic [1:0]           r_mode;
    logic                 r_out_valid;
    logic [KX_WORD_W-1:0] r_out_word;
    logic [KX_IDX_W-1:0]  r_out_idx;
    logic                 r_out_last;

    logic                 w_can_load;
    logic                 w_load;
    logic                 w_win_we;
    logic [KX_POS_W-1:0]  w_win_addr;
    logic [KX_WORD_W-1:0] n_word;
    logic [KX_IDX_W-1:0]  n_idx;
    logic                 n_last;
    logic [KX_WORD_W-1:0] w_t;
    logic                 w_sched_end;

    assign m_axis_tvalid = r_out_valid;
    assign o_word        = r_out_word;
    assign o_idx         = r_out_idx;
    assign o_last        = r_out_last;
    assign w_can_load    = !r_out_valid || m_axis_tready;
    assign w_sched_end   = (r_idx == kx_last_idx(r_mode));

    // recurrence for the next schedule word
    always_comb begin
        w_t = r_prev;
        if (r_r == '0) begin
            w_t = kx_sub_word({r_prev[23:0], r_prev[31:24]})
                  ^ {RCON[r_rc], 24'd0};
        end else if (kx_nk_m1(r_mode) == 3'd7 && r_r == 3'd4) begin
            w_t = kx_sub_word(r_prev);
        end
        w_t = w_t ^ r_window[r_r];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && w_can_load && i_q_item.last_key) begin
                    n_state = BK_EXPAND;
                end
            end
            BK_EXPAND: begin
                if (w_can_load && w_sched_end) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_pop    = 1'b0;
        w_load     = 1'b0;
        w_win_we   = 1'b0;
        w_win_addr = r_r;
        n_word     = w_t;
        n_idx      = r_idx;
        n_last     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && w_can_load) begin
                    o_q_pop    = 1'b1;
                    w_load     = 1'b1;
                    w_win_we   = 1'b1;
                    w_win_addr = i_q_item.pos;
                    n_word     = i_q_item.word;
                    n_idx      = KX_IDX_W'(i_q_item.pos);
                end
            end
            BK_EXPAND: begin
                if (w_can_load) begin
                    w_load   = 1'b1;
                    w_win_we = 1'b1;
                    n_last   = w_sched_end;
                end
            end
            default: ;
        endcase
    end

    // key window and output payload
    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_window[w_win_addr] <= n_word;
        end
        if (w_load) begin
            r_out_word <= n_word;
            r_out_idx  <= n_idx;
            r_out_last <= n_last;
            r_prev     <= n_word;
        end
    end

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_r         <= '0;
            r_rc        <= '0;
            r_mode      <= KX_MODE_256;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_IDLE && o_q_pop) begin
                r_mode <= i_q_item.mode;
                r_idx  <= KX_IDX_W'(kx_nk_m1(i_q_item.mode)) + 1'b1;
                r_r    <= '0;
                r_rc   <= KX_RCON_W'(1);
            end else if (r_state == BK_EXPAND && w_load) begin
                r_idx <= r_idx + 1'b1;
                if (r_r == kx_nk_m1(r_mode)) begin
                    r_r  <= '0;
                    r_rc <= r_rc + 1'b1;
                end else begin
                    r_r <= r_r + 1'b1;
                end
            end
        end
    end

    a_expand_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EXPAND |-> (r_r <= kx_nk_m1(r_mode) && r_idx <= kx_last_idx(r_mode)))
        else $error("expansion position out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_state == BK_IDLE)
        else $error("last word shown while expansion still running");

    a_no_pop_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EXPAND |-> !o_q_pop)
        else $error("queue popped during expansion");

endmodule

// File: rtl/aes_key_expansion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_expansion_top: AES-128/192/256 key schedule
// Usage:
//  - Write the key size code on the cfg channel (0 = 128, 1 = 192,
//    2 or 3 = 256 bit) while the block is idle; a write restarts key loading.
//    o_cfg_ready is always high. Reset selects 256-bit keys.
//  - Send cipher key words on s_axis, byte 0 in bits 31..24; 4, 6 or 8 words
//    make one key. Each item is echoed on m_axis as a round-key word.
//  - After the last key word the remaining 40, 46 or 52 schedule words follow
//    at one per cycle while not stalled; m_axis_tlast marks word 43, 51 or 59.
//  - Path: with the back end idle, an accepted key word goes into a queue entry
//    and then into the output register, from which m_axis shows it.
//  - Throughput: one schedule word per cycle while m_axis_tready allows,
//    limited by the single generator stage; a full key gives 4*(Nk+7)
//    output words, i.e. 44, 52 or 60.
//  - A two-entry queue lets s_axis take the next key words during an
//    expansion; s_axis_tready drops when that queue is full.
//  - When m_axis_tready is low the output register holds and the generator
//    waits; no word is dropped.
//  - Reset (i_rst_n low, synchronous) empties the queue and output register.
// ----------------------------------------------------------------------------
module aes_key_expansion_top
    import aeskx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: key size code
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    // key words in; tdata[31:0] = key_word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // schedule words out; tdata[31:0] = round_key_word, [37:32] = word_index,
    // [39:38] = zero; tlast = last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic                 w_q_push;
    logic                 w_q_full;
    logic                 w_q_valid;
    logic                 w_q_pop;
    t_kx_item             w_push_item;
    t_kx_item             w_pop_item;
    logic [KX_WORD_W-1:0] w_word;
    logic [KX_IDX_W-1:0]  w_idx;

    aeskx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_push_item)
    );

    aeskx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item),
        .i_pop   (w_q_pop)
    );

    aeskx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_pop_item),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_word        (w_word),
        .o_idx         (w_idx),
        .o_last        (m_axis_tlast)
    );

    // pack output fields, highest first
    assign m_axis_tdata = {2'b00, w_idx, w_word};

endmodule

// File: tb/tb_aes_key_expansion_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_key_expansion_top: self-checking bench for the AES key schedule
// Streams cipher key words of every key size into the block and checks each
// schedule item on m_axis against a predictor kept in a scoreboard class.
// Both stream sides idle at random; key size is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_aes_key_expansion_top;
    import aeskx_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 420;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 8;

    // one expected schedule item
    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  idx;
        logic        last;
    } t_sched_word;

    // Key schedule predictor and result checker
    class key_schedule_scoreboard;
        logic [1:0]  key_size;
        logic [31:0] window [8];
        int unsigned loaded;
        int unsigned errors;
        t_sched_word pending_words[$];

        function new();
            key_size = KX_MODE_256;
            loaded   = 0;
            errors   = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        // any key size write restarts key loading
        function void set_key_size(logic [1:0] m);
            key_size = m;
            loaded   = 0;
        endfunction

        function int unsigned outstanding();
            return pending_words.size();
        endfunction

        function logic [31:0] sbox_word(logic [31:0] w);
            logic [31:0] r;
            for (int b = 0; b < 4; b++) r[b*8 +: 8] = SBOX[w[b*8 +: 8]];
            return r;
        endfunction

        // note an accepted key word and queue every item it causes
        function void note_key_word(logic [31:0] w);
            int unsigned nk;
            int unsigned total;
            int unsigned pos;
            int unsigned r;
            logic [31:0] t;
            logic [31:0] prev;
            t_sched_word item;
            case (key_size)
                KX_MODE_128: nk = 4;
                KX_MODE_192: nk = 6;
                default:     nk = 8;
            endcase
            total = 4 * (nk + 7);
            if (total > 60) total = 60;
            if (loaded >= nk) loaded = 0;
            pos = loaded;
            window[pos] = w;
            loaded = pos + 1;
            item.word = w;
            item.idx  = 6'(pos);
            item.last = (loaded == total);
            pending_words.push_back(item);
            if (loaded < nk) return;
            // key complete: expand the rest of the schedule
            prev = w;
            for (int unsigned i = nk; i < total; i++) begin
                r = i % nk;
                t = prev;
                if (r == 0) begin
                    t = sbox_word({t[23:0], t[31:24]}) ^ {RCON[(i / nk) % 16], 24'h0};
                end else if (nk == 8 && r == 4) begin
                    t = sbox_word(t);
                end
                t = t ^ window[r];
                window[r] = t;
                prev = t;
                item.word = t;
                item.idx  = 6'(i);
                item.last = (i + 1 == total);
                pending_words.push_back(item);
            end
            loaded = 0;
        endfunction

        // compare one output item with the oldest expectation
        function void check_word(logic [39:0] data, logic last);
            t_sched_word e;
            if (pending_words.size() == 0) begin
                $error("unexpected schedule item: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (data[31:0] !== e.word) begin
                $error("round_key_word: expected %h, got %h", e.word, data[31:0]);
                errors++;
            end
            if (data[37:32] !== e.idx) begin
                $error("word_index: expected %0d, got %0d", e.idx, data[37:32]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_word: expected %b, got %b", e.last, last);
                errors++;
            end
            if (data[39:38] !== 2'b00) begin
                $error("tdata pad: expected 0, got %b", data[39:38]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    key_schedule_scoreboard sb = new();
    bit          calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    aes_key_expansion_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] key_word
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] round_key_word, [37:32] word_index
        .m_axis_tlast  (m_axis_tlast)    // last_word
    );

    always #CLK_HALF i_clk = ~i_clk;

    // output side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tdata, m_axis_tlast);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_aes_key_expansion_top failed");
            $finish;
        end
    end

    // drive one key word; returns at the accepting edge
    task automatic send_key_word(input logic [31:0] w);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_key_word(w);
        items_sent++;
    endtask

    task automatic hold_key_stream();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // wait until every expected item has come out, then let the block settle
    task automatic wait_drained(input int extra);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_key_size(input logic [1:0] m);
        hold_key_stream();
        wait_drained(SETTLE_CYCLES);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_key_size(m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_key_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic int unsigned words_for(logic [1:0] m);
        case (m)
            KX_MODE_128: return 4;
            KX_MODE_192: return 6;
            default:     return 8;
        endcase
    endfunction

    initial begin
        logic [1:0]  mode;
        int unsigned nk;
        int unsigned keys;
        int unsigned phase;
        int unsigned cut;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset key size (256 bit) with extreme words
        send_key_word(32'h0000_0000);
        send_key_word(32'hffff_ffff);
        send_key_word(32'h8000_0000);
        send_key_word(32'h0000_0001);
        send_key_word(32'h7fff_ffff);
        send_key_word(32'hffff_fffe);
        send_key_word(32'h5555_5555);
        send_key_word(32'haaaa_aaaa);

        // 128-bit key, standard example key
        write_key_size(KX_MODE_128);
        send_key_word(32'h2b7e_1516);
        send_key_word(32'h28ae_d2a6);
        send_key_word(32'habf7_1588);
        send_key_word(32'h09cf_4f3c);

        // 192-bit key
        write_key_size(KX_MODE_192);
        send_key_word(32'h8e73_b0f7);
        send_key_word(32'hda0e_6452);
        send_key_word(32'hc810_f32b);
        send_key_word(32'h8090_79e5);
        send_key_word(32'h62f8_ead2);
        send_key_word(32'h522c_6b7b);

        // unused code, cut short by a key size write mid-key
        write_key_size(2'd3);
        send_key_word(32'hffff_ffff);
        send_key_word(32'h0000_0000);
        send_key_word(32'hdead_beef);
        write_key_size(KX_MODE_128);
        send_key_word(32'hffff_ffff);
        send_key_word(32'hffff_ffff);
        send_key_word(32'hffff_ffff);
        send_key_word(32'hffff_ffff);

        // random phases: mostly whole keys, a few cut short by a rewrite
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (phase)
                0:       mode = KX_MODE_128;
                1:       mode = 2'd3;
                2:       mode = KX_MODE_192;
                3:       mode = KX_MODE_256;
                default: mode = 2'($urandom_range(0, 3));
            endcase
            write_key_size(mode);
            calm = (phase == 4);
            nk   = words_for(mode);
            keys = $urandom_range(2, 5);
            for (int k = 0; k < keys; k++) begin
                for (int j = 0; j < nk; j++) send_key_word(random_key_word());
            end
            if ($urandom_range(0, 99) < 30) begin
                cut = $urandom_range(1, nk - 1);
                for (int j = 0; j < cut; j++) send_key_word(random_key_word());
            end
            calm = 1'b0;
            phase++;
        end

        hold_key_stream();
        wait_drained(DRAIN_CYCLES);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_aes_key_expansion_top passed");
        end else begin
            $display("tb_aes_key_expansion_top failed");
        end
        $finish;
    end

endmodule
